@@ rtl/core/ilis_pkg.sv @@
package ilis_pkg;

    localparam int CAPACITY = 64;
    localparam int POS_W    = 8;
    localparam int ELEM_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int STAT_W   = 2;
    localparam int CMD_W    = 2;

    localparam int IN_DATA_W  = ((POS_W + ELEM_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((ELEM_W + CNT_W + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

    typedef struct packed {
        logic out_busy;
    } stat_t;

endpackage

@@ rtl/core/ilis_ctrl.sv @@
module ilis_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  ilis_pkg::stat_t stat,
    output ilis_pkg::ctrl_t ctrl
);
    import ilis_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign s_tready     = (state_reg == ST_IDLE);
    assign ctrl.capture = s_tvalid && (state_reg == ST_IDLE);
    assign ctrl.execute = (state_reg == ST_EXEC) && !stat.out_busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/ilis_datapath.sv @@
module ilis_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ilis_pkg::ctrl_t                   ctrl,
    output ilis_pkg::stat_t                   stat,
    input  logic [ilis_pkg::CMD_W-1:0]        in_command,
    input  logic [ilis_pkg::POS_W-1:0]        in_position,
    input  logic [ilis_pkg::ELEM_W-1:0]       in_element,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ilis_pkg::ELEM_W-1:0]       out_read_element,
    output logic [ilis_pkg::CNT_W-1:0]        out_element_count,
    output logic [ilis_pkg::STAT_W-1:0]       out_status
);
    import ilis_pkg::*;

    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CMD_W-1:0]  command_reg;
    logic [POS_W-1:0]  position_reg;
    logic [ELEM_W-1:0] element_reg;

    logic [ELEM_W-1:0] cell_reg  [CAPACITY];
    logic [ELEM_W-1:0] cell_next [CAPACITY];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic              out_valid_reg;
    logic [ELEM_W-1:0] rd_reg;
    logic [ELEM_W-1:0] rd_next;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;

    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  target;
    logic              in_range;
    logic              full;
    logic              want_insert;
    logic              do_insert;
    logic              do_write;

    assign count_ext   = CMP_W'(count_reg);
    assign pos_ext     = CMP_W'(position_reg);
    assign target      = (command_reg == CMD_APPEND) ? count_ext : pos_ext;
    assign in_range    = (pos_ext < count_ext);
    assign full        = (count_ext >= CAP_C) || (target >= CAP_C);
    assign want_insert = (command_reg == CMD_INSERT) || (command_reg == CMD_APPEND)
                         || ((command_reg == CMD_SET) && !in_range);
    assign do_insert   = want_insert && !full;
    assign do_write    = (command_reg == CMD_SET) && in_range;

    assign stat.out_busy = out_valid_reg && !out_ready;

    always_comb
    begin
        count_next  = count_reg;
        rd_next     = '0;
        status_next = STAT_OK;
        if (do_insert)
        begin
            if (target < count_ext)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                count_next = CNT_W'(target + CMP_W'(1));
            end
        end
        else if (want_insert)
        begin
            status_next = STAT_FULL;
        end
        if (command_reg == CMD_GET)
        begin
            if (in_range)
            begin
                rd_next = cell_reg[position_reg[IDX_W-1:0]];
            end
            else
            begin
                status_next = STAT_RANGE;
            end
        end
    end

    // cells above the count stay zero, so a shift or gap needs no explicit clear
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_next[i] = cell_reg[i];
            if ((do_insert || do_write) && (target == CMP_W'(i)))
            begin
                cell_next[i] = element_reg;
            end
            else if (do_insert && (target < CMP_W'(i)) && (i > 0))
            begin
                cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            command_reg  <= in_command;
            position_reg <= in_position;
            element_reg  <= in_element;
        end
        if (ctrl.execute)
        begin
            rd_reg      <= rd_next;
            cnt_out_reg <= count_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                cell_reg[i] <= '0;
            end
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.execute)
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    cell_reg[i] <= cell_next[i];
                end
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_read_element  = rd_reg;
    assign out_element_count = cnt_out_reg;
    assign out_status        = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CAP_C)
        else $error("element count exceeds capacity");

    a_exec_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |=> out_valid_reg)
        else $error("executed transaction not presented");

    a_refused_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.execute && (status_next != STAT_OK)) |=> $stable(count_reg))
        else $error("refused transaction changed count");

    a_no_exec_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.execute |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten while stalled");

endmodule

@@ rtl/core/indexed_list_insert_shift.sv @@
// Indexed list with insert-and-shift over a row of element cells.
// Input channel s_*: one command per transaction. s_tuser carries the command
// (0 get, 1 set, 2 insert at index, 3 append); s_tdata carries position and
// element. Output channel m_*: exactly one result per command, in order.
// m_tdata carries the element read by a get and the element count after the
// command; m_tuser carries the status (0 ok, 1 get out of range, 2 full).
// Sequence: the accepting edge captures the command; the execute edge, once
// the output register is free, shifts or updates the cell row in parallel
// and loads the output register. The capture/execute sequencer takes no new
// command until the previous one has executed, but a new command is taken
// while the previous result waits.
// Stall: while m_tready is low the result holds; a captured command waits
// in execute and s_tready stays low until the output register frees.
// Reset: asynchronous, active low; clears the count, all cells to zero and
// both channels to idle.
module indexed_list_insert_shift (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ilis_pkg::IN_DATA_W-1:0]    s_tdata,   // position[7:0], element[39:8]
    input  logic [ilis_pkg::CMD_W-1:0]        s_tuser,   // command[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ilis_pkg::OUT_DATA_W-1:0]   m_tdata,   // read_element[31:0], element_count[38:32]
    output logic [ilis_pkg::STAT_W-1:0]       m_tuser    // status[1:0]
);
    import ilis_pkg::*;

    ctrl_t             ctrl;
    stat_t             stat;
    logic [ELEM_W-1:0] read_element;
    logic [CNT_W-1:0]  element_count;

    ilis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ilis_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .ctrl              (ctrl),
        .stat              (stat),
        .in_command        (s_tuser),
        .in_position       (s_tdata[POS_W-1:0]),
        .in_element        (s_tdata[POS_W+ELEM_W-1:POS_W]),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_read_element  (read_element),
        .out_element_count (element_count),
        .out_status        (m_tuser)
    );

    assign m_tdata = OUT_DATA_W'({element_count, read_element});

endmodule
